// ----- design/dashed_line_rasterizer_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DASHED_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DASHED_LINE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dlr_pkg.sv -----
package dlr_pkg;

    // Field widths of the ports.
    localparam int COORD_W            = 6;
    localparam int RUN_W              = 8;
    localparam int CFG_INDEX_W        = 2;
    localparam int COORD_BITS_DEFAULT = 6;

    // Register reset values.
    localparam logic [RUN_W-1:0] DASH_RUN_RESET = 8'd10;
    localparam logic [RUN_W-1:0] GAP_RUN_RESET  = 8'd5;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_RUN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_RUN  = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } line_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               visible;
        logic               last_pixel;
    } pixel_t;

    // Controller -> datapath.
    typedef struct packed {
        logic load;   // set up a new line from the input transfer
        logic emit;   // write the current pixel into the output register
        logic step;   // advance to the next pixel
    } ctl_cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic last;      // current pixel is the end point
        logic out_free;  // output register can take a pixel this cycle
    } ctl_status_t;

endpackage

// ----- design/dlr_ctrl.sv -----
module dlr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 line_valid,
    output logic                 line_stall,
    input  dlr_pkg::ctl_status_t status,
    output dlr_pkg::ctl_cmd_t    cmd
);
    import dlr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        line_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                line_stall = 1'b0;
                if (line_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/dlr_datapath.sv -----
module dlr_datapath #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dlr_pkg::ctl_cmd_t               cmd,
    output dlr_pkg::ctl_status_t            status,
    input  dlr_pkg::line_t                  line_data,
    input  logic                            cfg_valid,
    input  logic [dlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dlr_pkg::RUN_W-1:0]       cfg_data,
    input  logic                            pixel_stall,
    output logic                            pixel_valid,
    output dlr_pkg::pixel_t                 pixel_data
);
    import dlr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int IW = COORD_BITS + 1;   // 2*major fits
    localparam int DW = COORD_BITS + 3;   // signed error term

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Registers
    logic [RUN_W-1:0]     dash_run_reg;
    logic [RUN_W-1:0]     gap_run_reg;
    logic [CB-1:0]        walk_x_reg, walk_x_next;
    logic [CB-1:0]        walk_y_reg, walk_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [CB-1:0]        steps_reg, steps_next;
    logic [RUN_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                 in_dash_reg, in_dash_next;
    logic                 neg_x_reg, neg_y_reg, x_major_reg;
    logic [IW-1:0]        diag_inc_reg, straight_inc_reg;
    logic                 pixel_valid_reg;
    pixel_t               pixel_data_reg;

    // Line set-up
    logic [CB-1:0]        sx, sy, ex, ey;
    logic                 neg_x, neg_y, x_major;
    logic [CB-1:0]        dx, dy, major, minor;
    logic signed [DW-1:0] dec_init;
    logic [IW-1:0]        diag_inc, straight_inc;

    assign sx = line_data.start_x[CB-1:0];
    assign sy = line_data.start_y[CB-1:0];
    assign ex = line_data.end_x[CB-1:0];
    assign ey = line_data.end_y[CB-1:0];

    assign neg_x   = ex < sx;
    assign neg_y   = ey < sy;
    assign dx      = neg_x ? (sx - ex) : (ex - sx);
    assign dy      = neg_y ? (sy - ey) : (ey - sy);
    assign x_major = dx > dy;
    assign major   = x_major ? dx : dy;
    assign minor   = x_major ? dy : dx;

    assign dec_init     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    assign diag_inc     = {major - minor, 1'b0};
    assign straight_inc = {minor, 1'b0};

    // One Bresenham step
    logic diag, move_x, move_y;
    logic run_done, switch_run;
    logic [RUN_W-1:0] run_base;

    assign diag   = ~decision_reg[DW-1];
    assign move_x = x_major_reg | diag;
    assign move_y = ~x_major_reg | diag;

    assign decision_next = diag ? (decision_reg - $signed({2'b00, diag_inc_reg}))
                                : (decision_reg + $signed({2'b00, straight_inc_reg}));
    assign walk_x_next = move_x ? (neg_x_reg ? walk_x_reg - 1'b1 : walk_x_reg + 1'b1)
                                : walk_x_reg;
    assign walk_y_next = move_y ? (neg_y_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1)
                                : walk_y_reg;
    assign steps_next  = steps_reg - 1'b1;

    // Dash/gap pattern: test the run, then count the new pixel (saturating).
    assign run_done     = in_dash_reg ? (run_cnt_reg >= dash_run_reg)
                                      : (run_cnt_reg >= gap_run_reg);
    assign switch_run   = run_done;
    assign in_dash_next = switch_run ? ~in_dash_reg : in_dash_reg;
    assign run_base     = switch_run ? '0 : run_cnt_reg;
    assign run_cnt_next = (run_base == RUN_MAX) ? run_base : run_base + 1'b1;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_run_reg <= DASH_RUN_RESET;
            gap_run_reg  <= GAP_RUN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DASH_RUN: dash_run_reg <= cfg_data;
                CFG_GAP_RUN:  gap_run_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg       <= '0;
            walk_y_reg       <= '0;
            decision_reg     <= '0;
            steps_reg        <= '0;
            run_cnt_reg      <= '0;
            in_dash_reg      <= 1'b1;
            neg_x_reg        <= 1'b0;
            neg_y_reg        <= 1'b0;
            x_major_reg      <= 1'b0;
            diag_inc_reg     <= '0;
            straight_inc_reg <= '0;
        end
        else if (cmd.load)
        begin
            walk_x_reg       <= sx;
            walk_y_reg       <= sy;
            decision_reg     <= dec_init;
            steps_reg        <= major;
            run_cnt_reg      <= RUN_W'(1);   // first pixel already counted
            in_dash_reg      <= 1'b1;
            neg_x_reg        <= neg_x;
            neg_y_reg        <= neg_y;
            x_major_reg      <= x_major;
            diag_inc_reg     <= diag_inc;
            straight_inc_reg <= straight_inc;
        end
        else if (cmd.step)
        begin
            walk_x_reg   <= walk_x_next;
            walk_y_reg   <= walk_y_next;
            decision_reg <= decision_next;
            steps_reg    <= steps_next;
            run_cnt_reg  <= run_cnt_next;
            in_dash_reg  <= in_dash_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            pixel_valid_reg <= 1'b1;
        end
        else if (!pixel_stall)
        begin
            pixel_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_data_reg.pixel_x    <= COORD_W'(walk_x_reg);
            pixel_data_reg.pixel_y    <= COORD_W'(walk_y_reg);
            pixel_data_reg.visible    <= in_dash_reg;
            pixel_data_reg.last_pixel <= (steps_reg == '0);
        end
    end

    assign status.last     = (steps_reg == '0);
    assign status.out_free = ~pixel_valid_reg | ~pixel_stall;

    assign pixel_valid = pixel_valid_reg;
    assign pixel_data  = pixel_data_reg;

endmodule

// ----- design/dashed_line_rasterizer_core.sv -----
// Dashed line rasterizer core.
// Line channel (line_valid / line_stall / line_data): one transfer gives the
//   start and end points of a line. line_stall is low only while the core is
//   idle; a new line is taken even if the final pixel of the previous line
//   still sits in the output register.
// Pixel channel (pixel_valid / pixel_stall / pixel_data): one transfer per
//   pixel along the major axis, start to end inclusive, with the dash/gap
//   visible flag and last_pixel set on the end point.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; index 0 is dash_run, index 1 is gap_run, others are dropped.
//   Write only while the core is idle.
// Flow: the line transfer loads the walk registers, then the first pixel is
//   written into the output register; afterwards one pixel per cycle while
//   pixel_stall is low. The Bresenham step unit in the datapath, shared over
//   all pixels of a line, sets that pace.
// Stall: a stalled pixel holds in the output register and the walk pauses.
// Reset (rst_n, async, active low): core idle, output empty, dash_run = 10,
//   gap_run = 5.
module dashed_line_rasterizer_core #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // line endpoints in
    input  logic                            line_valid,
    output logic                            line_stall,
    input  dlr_pkg::line_t                  line_data,
    // pixels out
    output logic                            pixel_valid,
    input  logic                            pixel_stall,
    output dlr_pkg::pixel_t                 pixel_data,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dlr_pkg::RUN_W-1:0]       cfg_data
);
    import dlr_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Registers are never busy.
    assign cfg_ready = 1'b1;

    // Sequencer: idle / walk.
    dlr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Set-up, Bresenham step, dash pattern, output register.
    dlr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .line_data   (line_data),
        .cfg_valid   (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_stall (pixel_stall),
        .pixel_valid (pixel_valid),
        .pixel_data  (pixel_data)
    );

endmodule

// ----- design/dlr_checker.sv -----
`include "dashed_line_rasterizer_core_defines.svh"

module dlr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            line_valid,
    input logic            line_stall,
    input logic            pixel_valid,
    input logic            pixel_stall,
    input dlr_pkg::pixel_t pixel_data
);
    import dlr_pkg::*;

    // stalled pixel is held
    `DLR_ASSERT_NEXT(a_pixel_hold, clk, rst_n,
        pixel_valid && pixel_stall,
        pixel_valid && $stable(pixel_data), "stalled pixel changed")

    // a taken line keeps the core busy next cycle
    `DLR_ASSERT_NEXT(a_busy_after_line, clk, rst_n,
        line_valid && !line_stall,
        line_stall, "core not busy after line transfer")

    // a non-final pixel leaving means the walk is still running
    `DLR_ASSERT_NOW(a_busy_mid_line, clk, rst_n,
        pixel_valid && !pixel_stall && !pixel_data.last_pixel,
        line_stall, "core idle in mid line")

    // when idle, only the final pixel of a line can be pending
    `DLR_ASSERT_NOW(a_idle_last_only, clk, rst_n,
        pixel_valid && !line_stall,
        pixel_data.last_pixel, "idle with non-final pixel pending")

endmodule

bind dashed_line_rasterizer_core dlr_checker u_dlr_checker (.*);
